@@ rtl/mpld_pkg.sv @@
// Shared types and constants for the multi-pin lockout debouncer.
package mpld_pkg;

   // Number of pins that may be buttons (1 to 32)
   localparam int PIN_COUNT = 32;
   localparam int DATA_W    = 32;
   localparam int DEB_W     = 8;
   localparam int QUERY_W   = 5;
   localparam int IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int CSR_IDX_W = 2;

   // Pins at or above PIN_COUNT are never buttons
   localparam logic [DATA_W-1:0] PIN_RANGE_MASK =
      (PIN_COUNT >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << PIN_COUNT) - DATA_W'(1));

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUTTON_MASK = 2'd0,
      REG_DEBOUNCE_MS = 2'd1
   } reg_index_type;

   // Command from the sequencer to the per-pin time unit
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             write;
   } pin_cmd_type;

endpackage

@@ rtl/mpld_time_unit.sv @@
// Per-pin toggle time store with the shared elapsed-time compare.
module mpld_time_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  mpld_pkg::pin_cmd_type          cmd,
   input  logic [mpld_pkg::DATA_W-1:0]    now_ms,
   input  logic [mpld_pkg::DEB_W-1:0]     debounce_ms,
   output logic                           expired
);

   logic [mpld_pkg::DATA_W-1:0] toggle_time_ff [mpld_pkg::PIN_COUNT];
   logic [mpld_pkg::DATA_W-1:0] elapsed;

   // Elapsed time since the selected pin last toggled, modulo 2^32
   always_comb begin
      elapsed = now_ms - toggle_time_ff[cmd.idx];
      expired = elapsed > mpld_pkg::DATA_W'(debounce_ms);
   end

   // Store the sample time when the selected pin toggles
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpld_pkg::PIN_COUNT; i++) begin
            toggle_time_ff[i] <= '0;
         end
      end else if (cmd.write) begin
         toggle_time_ff[cmd.idx] <= now_ms;
      end
   end

endmodule

@@ rtl/multi_pin_lockout_debouncer_unit.sv @@
// Top level of the multi-pin lockout debouncer: sequencer, state and result register.
// One poll sample in, one result out. With debounce_ms at zero an accepted sample goes
// straight on to result load and return to idle. Otherwise the block visits the pins
// one per cycle through a single elapsed-time subtract and compare, then loads the
// result and returns to idle; req_ready is low during the scan. The result waits in
// an output register, so a new sample is taken while an earlier result is still held;
// a finished sample waits in result load for that register to empty.
module multi_pin_lockout_debouncer_unit (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mpld_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mpld_pkg::DATA_W-1:0]        csr_wdata,
   // poll samples
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mpld_pkg::DATA_W-1:0]        req_raw_pins,
   input  logic [mpld_pkg::DATA_W-1:0]        req_now_ms,
   input  logic [mpld_pkg::QUERY_W-1:0]       req_query_pin,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mpld_pkg::DATA_W-1:0]        rsp_debounced_mask,
   output logic [mpld_pkg::DATA_W-1:0]        rsp_previous_mask,
   output logic                               rsp_any_change,
   output logic                               rsp_pin_pressed,
   output logic                               rsp_pin_changed,
   output logic                               rsp_pin_just_pressed,
   output logic                               rsp_pin_just_released
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [mpld_pkg::DATA_W-1:0]        button_mask_ff;
   logic [mpld_pkg::DEB_W-1:0]         debounce_ms_ff;
   logic [mpld_pkg::DATA_W-1:0]        deb_ff, deb_in;
   logic [mpld_pkg::DATA_W-1:0]        prev_ff, prev_in;
   logic [mpld_pkg::DATA_W-1:0]        sample_ff, sample_in;
   logic [mpld_pkg::DATA_W-1:0]        now_ff, now_in;
   logic [mpld_pkg::QUERY_W-1:0]       query_ff, query_in;
   logic                               change_ff, change_in;
   logic [mpld_pkg::IDX_W-1:0]         cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mpld_pkg::DATA_W-1:0]        out_deb_ff, out_deb_in;
   logic [mpld_pkg::DATA_W-1:0]        out_prev_ff, out_prev_in;
   logic                               out_change_ff, out_change_in;
   logic                               out_pressed_ff, out_pressed_in;
   logic                               out_changed_ff, out_changed_in;

   logic [mpld_pkg::DATA_W-1:0]        enabled;
   logic [mpld_pkg::DATA_W-1:0]        masked_sample;
   logic [mpld_pkg::PIN_COUNT-1:0]     enabled_lane;
   logic [mpld_pkg::PIN_COUNT-1:0]     deb_lane;
   logic [mpld_pkg::PIN_COUNT-1:0]     sample_lane;
   logic                               req_accept;
   logic                               out_free;
   logic                               toggle;
   logic                               expired;
   mpld_pkg::pin_cmd_type              pin_cmd;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign enabled = button_mask_ff & mpld_pkg::PIN_RANGE_MASK;
   assign masked_sample = ~req_raw_pins & enabled;
   assign enabled_lane = enabled[mpld_pkg::PIN_COUNT-1:0];
   assign deb_lane = deb_ff[mpld_pkg::PIN_COUNT-1:0];
   assign sample_lane = sample_ff[mpld_pkg::PIN_COUNT-1:0];

   // Toggle the visited pin when it is enabled, differs and its lockout has run out
   assign toggle = (state_ff == ST_SCAN) && enabled_lane[cnt_ff] &&
                   (deb_lane[cnt_ff] != sample_lane[cnt_ff]) && expired;

   assign pin_cmd.idx = cnt_ff;
   assign pin_cmd.write = toggle;

   mpld_time_unit u_time (
      .clock       (clock),
      .reset       (reset),
      .cmd         (pin_cmd),
      .now_ms      (now_ff),
      .debounce_ms (debounce_ms_ff),
      .expired     (expired)
   );

   // Sequencer: accept, scan the pins unless debounce_ms is zero, hand the result over
   always_comb begin
      state_in = state_ff;
      deb_in = deb_ff;
      prev_in = prev_ff;
      sample_in = sample_ff;
      now_in = now_ff;
      query_in = query_ff;
      change_in = change_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_deb_in = out_deb_ff;
      out_prev_in = out_prev_ff;
      out_change_in = out_change_ff;
      out_pressed_in = out_pressed_ff;
      out_changed_in = out_changed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               prev_in = deb_ff;
               sample_in = masked_sample;
               now_in = req_now_ms;
               query_in = req_query_pin;
               cnt_in = '0;
               if (debounce_ms_ff == '0) begin
                  deb_in = masked_sample;
                  change_in = (masked_sample != deb_ff);
                  state_in = ST_DONE;
               end else begin
                  change_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (toggle) begin
               deb_in = deb_ff ^ (mpld_pkg::DATA_W'(1) << cnt_ff);
               change_in = 1'b1;
            end
            if (cnt_ff == mpld_pkg::IDX_W'(mpld_pkg::PIN_COUNT - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + mpld_pkg::IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_deb_in = deb_ff;
               out_prev_in = prev_ff;
               out_change_in = change_ff;
               out_pressed_in = deb_ff[query_ff];
               out_changed_in = deb_ff[query_ff] ^ prev_ff[query_ff];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control, debounced state and the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         deb_ff <= '0;
         prev_ff <= '0;
         change_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         button_mask_ff <= '0;
         debounce_ms_ff <= '0;
      end else begin
         state_ff <= state_in;
         deb_ff <= deb_in;
         prev_ff <= prev_in;
         change_ff <= change_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mpld_pkg::REG_BUTTON_MASK: button_mask_ff <= csr_wdata;
               mpld_pkg::REG_DEBOUNCE_MS: debounce_ms_ff <= csr_wdata[mpld_pkg::DEB_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Hold the sample and the result payload
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      now_ff <= now_in;
      query_ff <= query_in;
      out_deb_ff <= out_deb_in;
      out_prev_ff <= out_prev_in;
      out_change_ff <= out_change_in;
      out_pressed_ff <= out_pressed_in;
      out_changed_ff <= out_changed_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_debounced_mask = out_deb_ff;
   assign rsp_previous_mask = out_prev_ff;
   assign rsp_any_change = out_change_ff;
   assign rsp_pin_pressed = out_pressed_ff;
   assign rsp_pin_changed = out_changed_ff;
   assign rsp_pin_just_pressed = out_changed_ff & out_pressed_ff;
   assign rsp_pin_just_released = out_changed_ff & ~out_pressed_ff;

endmodule
